// ===== src/pstb_pkg.sv =====
package pstb_pkg;

    localparam int LOC_W          = 32;
    localparam int OFF_W          = 32;
    localparam int POST_W         = 32;
    localparam int LEN_W          = 3;
    localparam int OUT_BUCKET_W   = 8;
    localparam int DEF_BUCKET_BITS = 8;

    typedef enum logic [1:0] {
        CMD_START  = 2'd0,
        CMD_ADD    = 2'd1,
        CMD_LOOKUP = 2'd2
    } t_cmd;

    // one seek table entry
    typedef struct packed {
        logic [OFF_W-1:0]  offset;
        logic [LOC_W-1:0]  location;
        logic [POST_W-1:0] posting;
    } t_entry;

endpackage

// ===== src/posting_seek_table_builder.sv =====
// Channel   | Handshake                | Payload
// ----------+--------------------------+-------------------------------------------
// request   | i_in_valid / o_in_ready  | i_command, i_delta, i_encoded_len,
//           |                          | i_query_location
// result    | o_out_valid / i_out_ready| o_found, o_entry_offset, o_entry_location,
//           |                          | o_entry_posting, o_bucket
//
// Two stages: a request register (stage A) and a result register (stage B).
// One request per cycle while the result is not stalled; each result passes from the
// request register into the result register before it can leave.
// Stage A does the running sums or the priority encode over the bucket valid
// bits; the table memory read is registered into stage B.
// Synchronous active-low reset clears valid bits, counters and the pipeline;
// the entry memory is not reset, valid bits gate every read of it.
// A stall holds B and a full A; table state only changes as stage A advances.
module posting_seek_table_builder
    import pstb_pkg::*;
#(
    parameter int BUCKET_BITS = DEF_BUCKET_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,

    input  logic                    i_in_valid,
    output logic                    o_in_ready,
    input  logic [1:0]              i_command,
    input  logic [LOC_W-1:0]        i_delta,
    input  logic [LEN_W-1:0]        i_encoded_len,
    input  logic [LOC_W-1:0]        i_query_location,

    output logic                    o_out_valid,
    input  logic                    i_out_ready,
    output logic                    o_found,
    output logic [OFF_W-1:0]        o_entry_offset,
    output logic [LOC_W-1:0]        o_entry_location,
    output logic [POST_W-1:0]       o_entry_posting,
    output logic [OUT_BUCKET_W-1:0] o_bucket
);

    localparam int DEPTH = 1 << BUCKET_BITS;

    // stage A: accepted request
    logic                r_a_valid;
    t_cmd                r_a_cmd;
    logic [LOC_W-1:0]    r_a_delta;
    logic [LEN_W-1:0]    r_a_elen;
    logic [LOC_W-1:0]    r_a_query;

    // running state
    logic [LOC_W-1:0]    r_run_loc;
    logic [OFF_W-1:0]    r_run_off;
    logic [POST_W-1:0]   r_post_cnt;
    logic [DEPTH-1:0]    r_filled;

    // entry memory, one write and one registered read port
    t_entry              r_mem [DEPTH];
    t_entry              r_rd;

    // stage B: result register
    logic                   r_b_valid;
    logic                   r_b_lookup;
    logic                   r_b_found;
    logic [OFF_W-1:0]       r_b_off;
    logic [LOC_W-1:0]       r_b_loc;
    logic [POST_W-1:0]      r_b_post;
    logic [BUCKET_BITS-1:0] r_b_bucket;

    logic                   a_adv;
    logic                   a_fire;
    logic [LOC_W-1:0]       n_run_loc;
    logic [OFF_W-1:0]       n_run_off;
    logic [BUCKET_BITS-1:0] add_bkt;
    logic [BUCKET_BITS-1:0] qry_bkt;
    logic                   add_first;
    logic [DEPTH-1:0]       masked;
    logic                   hit;
    logic [BUCKET_BITS-1:0] hit_idx;

    logic                   n_b_found;
    logic [OFF_W-1:0]       n_b_off;
    logic [LOC_W-1:0]       n_b_loc;
    logic [POST_W-1:0]      n_b_post;
    logic [BUCKET_BITS-1:0] n_b_bucket;

    // whole pipe moves unless the result waits
    assign a_adv      = !r_b_valid || i_out_ready;
    assign a_fire     = r_a_valid && a_adv;
    assign o_in_ready = !r_a_valid || a_adv;

    // add path
    assign n_run_loc = r_run_loc + r_a_delta;
    assign n_run_off = r_run_off + OFF_W'(r_a_elen);
    assign add_bkt   = n_run_loc[LOC_W-1 -: BUCKET_BITS];
    assign add_first = !r_filled[add_bkt];

    // lookup path: highest valid bucket at or below the query bucket
    assign qry_bkt = r_a_query[LOC_W-1 -: BUCKET_BITS];

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            masked[i] = r_filled[i] && (i <= int'(qry_bkt));
        end
    end

    always_comb begin
        hit     = 1'b0;
        hit_idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (masked[i]) begin
                hit     = 1'b1;
                hit_idx = BUCKET_BITS'(i);
            end
        end
    end

    always_comb begin
        n_b_found  = 1'b0;
        n_b_off    = '0;
        n_b_loc    = '0;
        n_b_post   = '0;
        n_b_bucket = '0;
        case (r_a_cmd)
            CMD_ADD: begin
                n_b_found  = add_first;
                n_b_off    = n_run_off;
                n_b_loc    = n_run_loc;
                n_b_post   = r_post_cnt;
                n_b_bucket = add_bkt;
            end
            CMD_LOOKUP: begin
                n_b_found  = hit;
                n_b_bucket = qry_bkt;
            end
            default: begin
            end
        endcase
    end

    // request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_a_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_a_cmd   <= t_cmd'(i_command);
            r_a_delta <= i_delta;
            r_a_elen  <= i_encoded_len;
            r_a_query <= i_query_location;
        end
    end

    // running state and valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run_loc  <= '0;
            r_run_off  <= '0;
            r_post_cnt <= '0;
            r_filled   <= '0;
        end else if (a_fire) begin
            case (r_a_cmd)
                CMD_START: begin
                    r_run_loc  <= '0;
                    r_run_off  <= '0;
                    r_post_cnt <= '0;
                    r_filled   <= '0;
                end
                CMD_ADD: begin
                    r_run_loc  <= n_run_loc;
                    r_run_off  <= n_run_off;
                    r_post_cnt <= r_post_cnt + POST_W'(1);
                    r_filled[add_bkt] <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // entry memory
    always_ff @(posedge i_clk) begin
        if (a_fire && r_a_cmd == CMD_ADD && add_first) begin
            r_mem[add_bkt] <= '{offset: n_run_off, location: n_run_loc, posting: r_post_cnt};
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_rd <= r_mem[hit_idx];
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (a_adv) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_fire) begin
            r_b_lookup <= (r_a_cmd == CMD_LOOKUP);
            r_b_found  <= n_b_found;
            r_b_off    <= n_b_off;
            r_b_loc    <= n_b_loc;
            r_b_post   <= n_b_post;
            r_b_bucket <= n_b_bucket;
        end
    end

    // lookup hits take their fields from the memory read
    assign o_out_valid      = r_b_valid;
    assign o_found          = r_b_found;
    assign o_entry_offset   = (r_b_lookup && r_b_found) ? r_rd.offset   : r_b_off;
    assign o_entry_location = (r_b_lookup && r_b_found) ? r_rd.location : r_b_loc;
    assign o_entry_posting  = (r_b_lookup && r_b_found) ? r_rd.posting  : r_b_post;
    assign o_bucket         = OUT_BUCKET_W'(r_b_bucket);

    // start empties the table
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_fire && r_a_cmd == CMD_START) |=> (r_filled == '0))
        else $error("valid bits not cleared by start");

    // an add marks its bucket filled
    a_add_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_fire && r_a_cmd == CMD_ADD) |=> r_filled[$past(add_bkt)])
        else $error("add left its bucket empty");

    // posting ordinal steps by one per add
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_fire && r_a_cmd == CMD_ADD) |=> (r_post_cnt == $past(r_post_cnt) + POST_W'(1)))
        else $error("posting count did not advance");

    // stalled lookup hit keeps its memory read data
    a_rd_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && r_b_lookup && r_b_found && !i_out_ready) |=> $stable(r_rd))
        else $error("read data changed under stall");

    // a lookup hit only ever comes from a filled table
    a_hit_needs_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (a_fire && r_a_cmd == CMD_LOOKUP && hit) |-> r_filled[hit_idx])
        else $error("lookup hit on empty bucket");

endmodule
